/* design/wcts_pkg.sv */
package wcts_pkg;
   localparam int NumSlots = 16;
   localparam int SlotW = 4;
   localparam int IdW = 16;
   localparam int CreditW = 16;
   localparam int PrioW = 6;
   localparam int MaxPriority = 32;
   localparam logic [IdW-1:0] IdReset = IdW'(123);

   typedef enum logic [2:0] {
      ACT_CREATE = 3'd0, ACT_DESTROY = 3'd1, ACT_SUSPEND = 3'd2, ACT_RESUME = 3'd3,
      ACT_SETPRIO = 3'd4, ACT_EXIT = 3'd5, ACT_SCHED = 3'd6, ACT_QUERY = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      ST_READY = 2'd0, ST_RUNNING = 2'd1, ST_SUSPENDED = 2'd2, ST_STOPPED = 2'd3
   } tstate_type;

   typedef enum logic [1:0] {
      RC_OK = 2'd0, RC_ARG = 2'd1, RC_STATE = 2'd2, RC_FULL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE = 4'b0001, FSM_CRED = 4'b0010, FSM_PICK = 4'b0100, FSM_DONE = 4'b1000
   } fsm_type;
endpackage

/* design/weighted_credit_thread_scheduler.sv */
// Weighted credit thread scheduler, 16-slot thread table shared by two cores.
// Non-schedule actions write their result straight into the output register; schedule
// makes one pass through the slots for credit update and one for selection.
// Throughput: one transaction at a time; req_stall high while busy or output held.
// Reset (synchronous, active high): table empty, no current threads, next id 123.
module weighted_credit_thread_scheduler (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_action,
   input  logic                    req_core,
   input  logic [3:0]              req_slot,
   input  logic [15:0]             req_thread_id,
   input  logic [5:0]              req_priority_req,
   input  logic                    req_in_interrupt,
   input  logic                    req_is_guarded,
   input  logic [15:0]             req_overflow_mask,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [3:0]              rsp_slot_out,
   output logic [15:0]             rsp_id_out,
   output logic [1:0]              rsp_state_out,
   output logic [5:0]              rsp_priority_out,
   output logic                    rsp_next_valid,
   output logic                    rsp_pend_switch
);
   import wcts_pkg::*;

   logic [NumSlots-1:0]   occ_ff, occ_in;
   logic [IdW-1:0]        sid_ff [NumSlots];
   logic [PrioW-1:0]      pri_ff [NumSlots];
   tstate_type            st_ff  [NumSlots];
   logic [CreditW-1:0]    cr_ff  [NumSlots];
   logic [IdW-1:0]        sid_in [NumSlots];
   logic [PrioW-1:0]      pri_in [NumSlots];
   tstate_type            st_in  [NumSlots];
   logic [CreditW-1:0]    cr_in  [NumSlots];
   logic [1:0]            cv_ff, cv_in;
   logic [SlotW-1:0]      cs_ff [2];
   logic [SlotW-1:0]      cs_in [2];
   logic [IdW-1:0]        nid_ff, nid_in;
   fsm_type               fsm_ff, fsm_in;
   logic [SlotW-1:0]      idx_ff, idx_in;
   logic                  core_ff, core_in;
   logic [NumSlots-1:0]   ovf_ff, ovf_in;
   logic                  found_ff, found_in;
   logic [SlotW-1:0]      best_ff, best_in;
   logic [CreditW-1:0]    bcr_ff, bcr_in;
   logic                  ov_ff, ov_in;
   logic [1:0]            o_status_ff, o_status_in;
   logic [SlotW-1:0]      o_slot_ff, o_slot_in;
   logic [IdW-1:0]        o_id_ff, o_id_in;
   logic [1:0]            o_st_ff, o_st_in;
   logic [PrioW-1:0]      o_pr_ff, o_pr_in;
   logic                  o_nv_ff, o_nv_in;
   logic                  o_pend_ff, o_pend_in;

   logic                  accept, hok, prio_ok, is_self, any_free;
   logic [SlotW-1:0]      free_idx, cslot;
   logic [CreditW:0]      sum;
   tstate_type            tst;

   assign req_stall = (fsm_ff != FSM_IDLE) || ov_ff;
   assign accept = req_valid && !req_stall;
   assign tst = st_ff[req_slot];
   assign hok = occ_ff[req_slot] && (sid_ff[req_slot] == req_thread_id);
   assign prio_ok = (req_priority_req >= PrioW'(1)) && (req_priority_req <= PrioW'(MaxPriority));
   assign is_self = cv_ff[req_core] && (cs_ff[req_core] == req_slot);
   assign cslot = cs_ff[req_core];
   assign sum = {1'b0, cr_ff[idx_ff]} + {{(CreditW+1-PrioW){1'b0}}, pri_ff[idx_ff]};

   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = NumSlots - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            any_free = 1'b1;
            free_idx = SlotW'(i);
         end
      end
   end

   always_comb begin
      occ_in = occ_ff; sid_in = sid_ff; pri_in = pri_ff; st_in = st_ff; cr_in = cr_ff;
      cv_in = cv_ff; cs_in = cs_ff; nid_in = nid_ff; fsm_in = fsm_ff; idx_in = idx_ff;
      core_in = core_ff; ovf_in = ovf_ff; found_in = found_ff; best_in = best_ff;
      bcr_in = bcr_ff; ov_in = ov_ff;
      o_status_in = o_status_ff; o_slot_in = o_slot_ff; o_id_in = o_id_ff;
      o_st_in = o_st_ff; o_pr_in = o_pr_ff; o_nv_in = o_nv_ff; o_pend_in = o_pend_ff;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (fsm_ff)
         FSM_IDLE: begin
            if (accept) begin
               o_status_in = RC_OK; o_slot_in = '0; o_id_in = '0; o_st_in = '0;
               o_pr_in = '0; o_nv_in = 1'b0; o_pend_in = 1'b0; ov_in = 1'b1;
               case (action_type'(req_action))
                  ACT_CREATE: begin
                     if (!prio_ok) o_status_in = RC_ARG;
                     else begin
                        nid_in = nid_ff + IdW'(1);
                        if (!any_free) o_status_in = RC_FULL;
                        else begin
                           occ_in[free_idx] = 1'b1;
                           sid_in[free_idx] = nid_ff;
                           pri_in[free_idx] = req_priority_req;
                           st_in[free_idx] = ST_READY;
                           cr_in[free_idx] = '0;
                           o_slot_in = free_idx;
                           o_id_in = nid_ff;
                        end
                     end
                  end
                  ACT_DESTROY: begin
                     if (!hok) o_status_in = RC_ARG;
                     else if (tst != ST_STOPPED) o_status_in = RC_STATE;
                     else occ_in[req_slot] = 1'b0;
                  end
                  ACT_SUSPEND: begin
                     if (!hok) o_status_in = RC_ARG;
                     else if ((tst != ST_READY && tst != ST_RUNNING) ||
                              (is_self && !req_in_interrupt && req_is_guarded))
                        o_status_in = RC_STATE;
                     else begin
                        st_in[req_slot] = ST_SUSPENDED;
                        o_pend_in = is_self;
                     end
                  end
                  ACT_RESUME: begin
                     if (!hok) o_status_in = RC_ARG;
                     else if (tst != ST_SUSPENDED) o_status_in = RC_STATE;
                     else st_in[req_slot] = ST_READY;
                  end
                  ACT_SETPRIO: begin
                     if (!hok || !prio_ok) o_status_in = RC_ARG;
                     else pri_in[req_slot] = req_priority_req;
                  end
                  ACT_EXIT: begin
                     if (!req_in_interrupt) begin
                        if (!cv_ff[req_core] || !occ_ff[cslot]) o_status_in = RC_STATE;
                        else begin
                           st_in[cslot] = ST_STOPPED;
                           o_pend_in = 1'b1;
                        end
                     end
                  end
                  ACT_SCHED: begin
                     ov_in = 1'b0;
                     if (cv_ff[req_core] && occ_ff[cslot] && st_ff[cslot] == ST_RUNNING)
                        st_in[cslot] = ST_READY;
                     cv_in[req_core] = 1'b0;
                     core_in = req_core;
                     ovf_in = req_overflow_mask[NumSlots-1:0];
                     idx_in = '0;
                     found_in = 1'b0;
                     fsm_in = FSM_CRED;
                  end
                  ACT_QUERY: begin
                     if (!hok) o_status_in = RC_ARG;
                     else begin
                        o_st_in = tst;
                        o_pr_in = pri_ff[req_slot];
                     end
                  end
                  default: ;
               endcase
            end
         end
         FSM_CRED: begin
            if (occ_ff[idx_ff]) begin
               cr_in[idx_ff] = sum[CreditW] ? '1 : sum[CreditW-1:0];
               if (ovf_ff[idx_ff]) st_in[idx_ff] = ST_STOPPED;
            end
            idx_in = idx_ff + SlotW'(1);
            if (idx_ff == SlotW'(NumSlots - 1)) fsm_in = FSM_PICK;
         end
         FSM_PICK: begin
            if (occ_ff[idx_ff] && st_ff[idx_ff] == ST_READY &&
                (!found_ff || cr_ff[idx_ff] > bcr_ff)) begin
               found_in = 1'b1;
               best_in = idx_ff;
               bcr_in = cr_ff[idx_ff];
            end
            idx_in = idx_ff + SlotW'(1);
            if (idx_ff == SlotW'(NumSlots - 1)) fsm_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (found_ff) begin
               st_in[best_ff] = ST_RUNNING;
               cr_in[best_ff] = '0;
               cv_in[core_ff] = 1'b1;
               cs_in[core_ff] = best_ff;
               o_nv_in = 1'b1;
               o_slot_in = best_ff;
               o_id_in = sid_ff[best_ff];
            end
            ov_in = 1'b1;
            fsm_in = FSM_IDLE;
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sid_ff <= sid_in; pri_ff <= pri_in; st_ff <= st_in; cr_ff <= cr_in;
      idx_ff <= idx_in; core_ff <= core_in; ovf_ff <= ovf_in; best_ff <= best_in;
      bcr_ff <= bcr_in; found_ff <= found_in;
      o_status_ff <= o_status_in; o_slot_ff <= o_slot_in; o_id_ff <= o_id_in;
      o_st_ff <= o_st_in; o_pr_ff <= o_pr_in; o_nv_ff <= o_nv_in; o_pend_ff <= o_pend_in;
      if (reset) begin
         occ_ff <= '0; cv_ff <= '0; cs_ff <= '{default: '0}; nid_ff <= IdReset;
         fsm_ff <= FSM_IDLE; ov_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in; cv_ff <= cv_in; cs_ff <= cs_in; nid_ff <= nid_in;
         fsm_ff <= fsm_in; ov_ff <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_status = o_status_ff;
   assign rsp_slot_out = o_slot_ff;
   assign rsp_id_out = o_id_ff;
   assign rsp_state_out = o_st_ff;
   assign rsp_priority_out = o_pr_ff;
   assign rsp_next_valid = o_nv_ff;
   assign rsp_pend_switch = o_pend_ff;
endmodule

/* design/wcts_checker.sv */
module wcts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_slot_out,
   input logic        rsp_next_valid,
   input logic        rsp_pend_switch
);
   import wcts_pkg::*;

   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepted while result pending");
   a_nv_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_next_valid |-> rsp_status == RC_OK) else $error("next_valid with error");
   a_pend_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pend_switch |-> rsp_status == RC_OK) else $error("pend with error");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot_out))
      else $error("stalled result changed");
endmodule

bind weighted_credit_thread_scheduler wcts_checker u_wcts_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_slot_out(rsp_slot_out), .rsp_next_valid(rsp_next_valid),
   .rsp_pend_switch(rsp_pend_switch)
);
